>>> hw/rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescape block.
`default_nettype none

package jsu_pkg;

  // Default depth of the job queue between front and back
  localparam int unsigned JsuQueueDepth = 4;

  typedef enum logic [2:0] {
    ErrNone   = 3'd0,
    ErrNoOpen = 3'd1,
    ErrCtrl   = 3'd2,
    ErrEscape = 3'd3,
    ErrHex    = 3'd4,
    ErrUnterm = 3'd5
  } err_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] error_code;
    logic       last;
  } out_t;

  // One queued job: up to three result beats from one input item
  typedef struct packed {
    logic [1:0]      last_idx;
    logic [2:0][7:0] bytes;
    logic            is_byte;
    logic            done;
    err_e            err;
  } job_t;

endpackage

`default_nettype wire

>>> hw/rtl/jsu_front.sv
// Front part: parses input beats and queues a job for each beat that completes an item.
`default_nettype none

module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  jsu_pkg::in_t  in_data_i,
  input  logic          q_ready_i,
  output logic          q_push_o,
  output jsu_pkg::job_t q_job_o
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeBody = 2'd1,
    ModeEsc  = 2'd2,
    ModeHex  = 2'd3
  } mode_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChLowB = 8'h62;
  localparam logic [7:0] ChLowF = 8'h66;
  localparam logic [7:0] ChLowN = 8'h6E;
  localparam logic [7:0] ChLowR = 8'h72;
  localparam logic [7:0] ChLowT = 8'h74;
  localparam logic [7:0] ChLowU = 8'h75;

  // Returns {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] cp_q, cp_d;
  logic [15:0] cp_new;
  logic [4:0]  hd;
  logic [7:0]  c;
  logic        accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign c          = in_data_i.in_byte;
  assign hd         = hex_digit(c);
  assign cp_new     = {cp_q[11:0], hd[3:0]};

  always_comb begin
    mode_d    = mode_q;
    hex_cnt_d = hex_cnt_q;
    cp_d      = cp_q;
    q_push_o  = 1'b0;
    q_job_o   = '{last_idx: 2'd0, bytes: '0, is_byte: 1'b0, done: 1'b0, err: ErrNone};
    if (accept) begin
      if (in_data_i.kind) begin
        q_push_o      = 1'b1;
        q_job_o.err   = (mode_q == ModeIdle) ? ErrNoOpen : ErrUnterm;
        mode_d        = ModeIdle;
        hex_cnt_d     = 2'd0;
        cp_d          = '0;
      end else begin
        case (mode_q)
          ModeIdle: begin
            if (c == ChQuote) begin
              mode_d    = ModeBody;
              hex_cnt_d = 2'd0;
              cp_d      = '0;
            end else if (c != ChSpace && c != ChTab && c != ChCr && c != ChLf) begin
              q_push_o    = 1'b1;
              q_job_o.err = ErrNoOpen;
            end
          end
          ModeBody: begin
            if (c == ChQuote) begin
              q_push_o     = 1'b1;
              q_job_o.done = 1'b1;
              mode_d       = ModeIdle;
              hex_cnt_d    = 2'd0;
              cp_d         = '0;
            end else if (c < ChSpace) begin
              q_push_o    = 1'b1;
              q_job_o.err = ErrCtrl;
              mode_d      = ModeIdle;
              hex_cnt_d   = 2'd0;
              cp_d        = '0;
            end else if (c == ChBslash) begin
              mode_d = ModeEsc;
            end else begin
              q_push_o        = 1'b1;
              q_job_o.is_byte = 1'b1;
              q_job_o.bytes[0] = c;
            end
          end
          ModeEsc: begin
            mode_d          = ModeBody;
            q_push_o        = 1'b1;
            q_job_o.is_byte = 1'b1;
            case (c)
              ChQuote, ChBslash, ChSlash: q_job_o.bytes[0] = c;
              ChLowB: q_job_o.bytes[0] = 8'h08;
              ChLowF: q_job_o.bytes[0] = 8'h0C;
              ChLowN: q_job_o.bytes[0] = 8'h0A;
              ChLowR: q_job_o.bytes[0] = 8'h0D;
              ChLowT: q_job_o.bytes[0] = 8'h09;
              ChLowU: begin
                q_push_o        = 1'b0;
                q_job_o.is_byte = 1'b0;
                mode_d          = ModeHex;
                hex_cnt_d       = 2'd0;
                cp_d            = '0;
              end
              default: begin
                q_job_o.is_byte = 1'b0;
                q_job_o.err     = ErrEscape;
                mode_d          = ModeIdle;
                hex_cnt_d       = 2'd0;
                cp_d            = '0;
              end
            endcase
          end
          ModeHex: begin
            if (!hd[4]) begin
              q_push_o    = 1'b1;
              q_job_o.err = ErrHex;
              mode_d      = ModeIdle;
              hex_cnt_d   = 2'd0;
              cp_d        = '0;
            end else if (hex_cnt_q == 2'd3) begin
              // fourth digit: emit the code point as UTF-8
              q_push_o        = 1'b1;
              q_job_o.is_byte = 1'b1;
              mode_d          = ModeBody;
              hex_cnt_d       = 2'd0;
              cp_d            = '0;
              if (cp_new[15:7] == 9'd0) begin
                q_job_o.bytes[0] = cp_new[7:0];
              end else if (cp_new[15:11] == 5'd0) begin
                q_job_o.last_idx = 2'd1;
                q_job_o.bytes[0] = {3'b110, cp_new[10:6]};
                q_job_o.bytes[1] = {2'b10, cp_new[5:0]};
              end else begin
                q_job_o.last_idx = 2'd2;
                q_job_o.bytes[0] = {4'b1110, cp_new[15:12]};
                q_job_o.bytes[1] = {2'b10, cp_new[11:6]};
                q_job_o.bytes[2] = {2'b10, cp_new[5:0]};
              end
            end else begin
              cp_d      = cp_new;
              hex_cnt_d = hex_cnt_q + 2'd1;
            end
          end
          default: mode_d = ModeIdle;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeIdle;
      hex_cnt_q <= 2'd0;
      cp_q      <= '0;
    end else begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      cp_q      <= cp_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/jsu_queue.sv
// Job queue between the front and back parts.
`default_nettype none

module jsu_queue #(
  parameter int unsigned Depth = jsu_pkg::JsuQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::job_t push_job_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output jsu_pkg::job_t head_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/jsu_back.sv
// Back part: expands queued jobs into result beats behind an output register.
`default_nettype none

module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  jsu_pkg::job_t q_head_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output jsu_pkg::out_t out_data_o
);
  import jsu_pkg::*;

  logic [1:0] idx_q;
  logic       out_valid_q;
  out_t       out_q, out_d;
  logic       advance, at_last;
  logic [7:0] sel_byte;

  assign advance = q_valid_i & (~out_valid_q | out_ready_i);
  assign at_last = (idx_q == q_head_i.last_idx);
  assign q_pop_o = advance & at_last;

  always_comb begin
    case (idx_q)
      2'd1:    sel_byte = q_head_i.bytes[1];
      2'd2:    sel_byte = q_head_i.bytes[2];
      default: sel_byte = q_head_i.bytes[0];
    endcase
    out_d.out_byte    = q_head_i.is_byte ? sel_byte : 8'h00;
    out_d.byte_valid  = q_head_i.is_byte;
    out_d.string_done = q_head_i.done;
    out_d.error_code  = q_head_i.err;
    out_d.last        = at_last;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        // step through the job's beats, rewind on its last one
        idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescape block with UTF-8 output.
//
//   channel | direction | handshake              | beat payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (kind, in_byte)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (out_byte,
//           |           |                        |   byte_valid, string_done,
//           |           |                        |   error_code, last)
//
// The front part takes one input beat per cycle while the job queue has room.
// An item yields zero to three result beats; the back part sends one per cycle
// while out_ready_i allows; an escape that decodes to three bytes holds it for all three.
// A result is registered on its way out: first by the queue write, then by the output register.
// Reset clears the parser state, the queue and the output valid; no clearing pass.
// Either side may stall; the job queue absorbs the difference up to QDepth jobs.
`default_nettype none

module json_string_unescape_utf8 #(
  parameter int unsigned QDepth = jsu_pkg::JsuQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  jsu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output jsu_pkg::out_t out_data_o
);
  import jsu_pkg::*;

  logic q_push, q_ready, q_pop, q_valid;
  job_t q_job, q_head;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_job_o    (q_job)
  );

  jsu_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_job),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> tb/jsu_checker.sv
// Checker for the JSON string unescape block: predicts result beats and compares them.
module jsu_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  jsu_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  jsu_pkg::out_t out_data_i,
  output int            errors_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    ScanIdle = 2'd0,
    InBody   = 2'd1,
    AfterEsc = 2'd2,
    InHex    = 2'd3
  } scan_e;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] CtrlLimit = 8'h20;
  localparam logic [7:0] Lead2   = 8'hC0;
  localparam logic [7:0] Lead3   = 8'hE0;
  localparam logic [7:0] ContMark = 8'h80;

  scan_e       scan;
  logic [1:0]  hex_cnt;
  logic [15:0] cp_acc;
  out_t        expected_beats[$];
  int          mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic push_result(input logic [7:0] value, input logic is_byte, input logic done,
                             input err_e err, input logic is_last);
    out_t beat;
    beat.out_byte    = value;
    beat.byte_valid  = is_byte;
    beat.string_done = done;
    beat.error_code  = err;
    beat.last        = is_last;
    expected_beats = {expected_beats, beat};
  endtask

  task automatic drop_to_idle(input err_e err);
    scan    = ScanIdle;
    hex_cnt = '0;
    cp_acc  = '0;
    if (err != ErrNone) push_result(8'h00, 1'b0, 1'b0, err, 1'b1);
  endtask

  task automatic push_utf8(input logic [15:0] cp);
    if (cp <= 16'h007F) begin
      push_result(cp[7:0], 1'b1, 1'b0, ErrNone, 1'b1);
    end else if (cp <= 16'h07FF) begin
      push_result(Lead2 | {3'b000, cp[10:6]}, 1'b1, 1'b0, ErrNone, 1'b0);
      push_result(ContMark | {2'b00, cp[5:0]}, 1'b1, 1'b0, ErrNone, 1'b1);
    end else begin
      push_result(Lead3 | {4'b0000, cp[15:12]}, 1'b1, 1'b0, ErrNone, 1'b0);
      push_result(ContMark | {2'b00, cp[11:6]}, 1'b1, 1'b0, ErrNone, 1'b0);
      push_result(ContMark | {2'b00, cp[5:0]}, 1'b1, 1'b0, ErrNone, 1'b1);
    end
  endtask

  task automatic decode_item(input in_t beat);
    logic [7:0] c;
    logic [3:0] nibble;
    logic       is_hex;
    c = beat.in_byte;
    if (beat.kind) begin
      drop_to_idle(scan == ScanIdle ? ErrNoOpen : ErrUnterm);
      return;
    end
    case (scan)
      ScanIdle: begin
        if (c == ChSpace || c == ChTab || c == ChCr || c == ChLf) begin
          // skip whitespace before the string
        end else if (c == ChQuote) begin
          scan    = InBody;
          hex_cnt = '0;
          cp_acc  = '0;
        end else begin
          drop_to_idle(ErrNoOpen);
        end
      end
      InBody: begin
        if (c == ChQuote) begin
          drop_to_idle(ErrNone);
          push_result(8'h00, 1'b0, 1'b1, ErrNone, 1'b1);
        end else if (c < CtrlLimit) begin
          drop_to_idle(ErrCtrl);
        end else if (c == ChBslash) begin
          scan = AfterEsc;
        end else begin
          push_result(c, 1'b1, 1'b0, ErrNone, 1'b1);
        end
      end
      AfterEsc: begin
        scan = InBody;
        case (c)
          ChQuote, ChBslash, ChSlash: push_result(c, 1'b1, 1'b0, ErrNone, 1'b1);
          ChB: push_result(8'h08, 1'b1, 1'b0, ErrNone, 1'b1);
          ChF: push_result(8'h0C, 1'b1, 1'b0, ErrNone, 1'b1);
          ChN: push_result(8'h0A, 1'b1, 1'b0, ErrNone, 1'b1);
          ChR: push_result(8'h0D, 1'b1, 1'b0, ErrNone, 1'b1);
          ChT: push_result(8'h09, 1'b1, 1'b0, ErrNone, 1'b1);
          ChU: begin
            scan    = InHex;
            hex_cnt = '0;
            cp_acc  = '0;
          end
          default: drop_to_idle(ErrEscape);
        endcase
      end
      default: begin
        is_hex = 1'b1;
        nibble = '0;
        if (c >= Ch0 && c <= Ch9) nibble = 4'(c - Ch0);
        else if (c >= ChLowA && c <= ChLowF) nibble = 4'(c - ChLowA + 8'd10);
        else if (c >= ChUpA && c <= ChUpF) nibble = 4'(c - ChUpA + 8'd10);
        else is_hex = 1'b0;
        if (!is_hex) begin
          drop_to_idle(ErrHex);
        end else begin
          cp_acc = {cp_acc[11:0], nibble};
          if (hex_cnt == 2'd3) begin
            push_utf8(cp_acc);
            scan    = InBody;
            hex_cnt = '0;
            cp_acc  = '0;
          end else begin
            hex_cnt = hex_cnt + 2'd1;
          end
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_beat(input out_t beat);
    out_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("result beat %0h with nothing expected", beat));
      return;
    end
    want = expected_beats.pop_front();
    compare_field("out_byte", beat.out_byte, want.out_byte);
    compare_field("byte_valid", 8'(beat.byte_valid), 8'(want.byte_valid));
    compare_field("string_done", 8'(beat.string_done), 8'(want.string_done));
    compare_field("error_code", 8'(beat.error_code), 8'(want.error_code));
    compare_field("last", 8'(beat.last), 8'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan       = ScanIdle;
      hex_cnt    = '0;
      cp_acc     = '0;
      mismatches = 0;
      expected_beats.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) decode_item(in_data_i);
      if (out_valid_i && out_ready_i) check_beat(out_data_i);
      errors_o  <= mismatches;
      pending_o <= expected_beats.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// Top of the testbench for the JSON string unescape block: clock, reset, stimulus, verdict.
module tb_top;
  import jsu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 2000;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] Ch0      = 8'h30;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChUpA    = 8'h41;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int errors;
  int pending;
  int send_idle_pct = 30;
  int recv_idle_pct = 61;
  int items_sent = 0;
  int quiet_cycles = 0;

  logic [7:0] ws_chars [4] = '{ChSpace, ChTab, ChCr, ChLf};
  logic [7:0] esc_chars [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};

  json_string_unescape_utf8 DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  jsu_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run when neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic is_end, input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: is_end, in_byte: value};
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_text(input logic [7:0] value);
    send_beat(1'b0, value);
  endtask

  task automatic send_noise();
    send_beat($urandom_range(3) == 0, 8'($urandom_range(255)));
  endtask

  // Hold the sender until every expected result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nibble);
    if (nibble < 4'd10) return Ch0 + 8'(nibble);
    if ($urandom_range(1)) return ChUpA + 8'(nibble) - 8'd10;
    return ChLowA + 8'(nibble) - 8'd10;
  endfunction

  task automatic send_unicode(input logic [15:0] cp);
    send_text(ChBslash);
    send_text(ChU);
    for (int i = 3; i >= 0; i--) send_text(hex_char(cp[i*4 +: 4]));
  endtask

  // Mostly well-formed strings with random content; a few carry noise or stop short.
  task automatic send_random_string();
    int         pieces;
    int         sel;
    logic [7:0] value;
    logic [15:0] cp;
    repeat ($urandom_range(2)) send_text(ws_chars[$urandom_range(3)]);
    send_text(ChQuote);
    pieces = $urandom_range(6);
    for (int i = 0; i < pieces; i++) begin
      sel = $urandom_range(99);
      if (sel < 4) begin
        send_noise();
      end else if (sel < 45) begin
        do value = 8'($urandom_range(8'h20, 8'hFF)); while (value == ChQuote || value == ChBslash);
        send_text(value);
      end else if (sel < 72) begin
        send_text(ChBslash);
        send_text(esc_chars[$urandom_range(7)]);
      end else begin
        case ($urandom_range(2))
          0: cp = 16'($urandom_range(16'h007F));
          1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
          default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        send_unicode(cp);
      end
    end
    if ($urandom_range(19) == 0) send_noise();
    else send_text(ChQuote);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: every idle case, control byte, high bytes, bad escape, \u extremes
    send_beat(1'b1, 8'hFF);
    send_text(ChSpace);
    send_text(8'h78);
    send_text(ChQuote);
    send_text(8'h1F);
    send_text(ChQuote);
    send_text(8'hFF);
    send_text(8'h7F);
    send_text(ChBslash);
    send_text(8'h71);
    send_text(ChQuote);
    send_unicode(16'h0000);
    send_unicode(16'hFFFF);
    send_text(ChQuote);
    send_text(ChQuote);
    send_text(ChBslash);
    send_text(ChU);
    send_text(8'h67);
    send_text(ChQuote);
    send_beat(1'b1, 8'h00);
    send_text(ChQuote);
    send_text(ChBslash);
    send_beat(1'b1, 8'h00);
    send_text(ChQuote);
    send_text(ChBslash);
    send_text(ChU);
    send_text(8'h41);
    send_beat(1'b1, 8'h00);

    while (items_sent < 120) send_random_string();
    drain_results();
    send_idle_pct = 61;
    recv_idle_pct = 30;
    while (items_sent < 225) send_random_string();
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < 320) send_random_string();

    drain_results();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
